/* hw/rtl/rsob_pkg.sv */
package rsob_pkg;

  // Channel and arithmetic widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned NumW    = 17;   // s*sA + dst part + oA/2 stays below 2^17
  localparam int unsigned QuotW   = 9;    // quotient bits 8..0, bit 8 flags saturation

  localparam logic [ChanW-1:0] ChanMax   = 8'd255;
  localparam logic [ChanW-1:0] RoundHalf = 8'd127;

  // x/255 = (x * 32897) >> 23, exact or one too high for x below 2^24
  localparam logic [15:0]  Recip255   = 16'd32897;
  localparam int unsigned  RecipShift = 23;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        CfgIdxBlendMode = 1'b0;

  typedef enum logic {
    MODE_OVER    = 1'b0,
    MODE_REPLACE = 1'b1
  } blend_mode_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pix_t;

  // Hand-off from the arithmetic front end to the divider
  typedef struct packed {
    logic [NumChan-1:0][NumW-1:0] num;   // rounded dividend per color channel
    logic [ChanW-1:0]             oa;    // output alpha, also the divisor
    logic                         byp;   // pass bpix straight through
    pix_t                         bpix;
  } div_in_t;

  // Fix the reciprocal estimate of x/255: step back by one if it overshoots
  function automatic logic [15:0] fix_div255(input logic [15:0] q_est,
                                             input logic [23:0] x);
    logic [23:0] back;
    back = {q_est, 8'd0} - {8'd0, q_est};
    return (back > x) ? (q_est - 16'd1) : q_est;
  endfunction

endpackage

/* hw/rtl/rsob_if.sv */
interface rsob_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface rsob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

/* hw/rtl/rsob_cfg.sv */
module rsob_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsob_pkg::CfgAddrW-1:0]    paddr,
  input  logic [rsob_pkg::CfgDataW-1:0]    pwdata,
  output logic [rsob_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready,
  output rsob_pkg::blend_mode_t            blend_mode
);

  rsob_pkg::blend_mode_t blend_mode_r;
  logic                  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rsob_pkg::CfgAddrW-1];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the mode register; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= rsob_pkg::MODE_OVER;
    end else if (wr_en && (reg_idx == rsob_pkg::CfgIdxBlendMode)) begin
      blend_mode_r <= rsob_pkg::blend_mode_t'(pwdata[0]);
    end
  end

  // Read back
  always_comb begin
    if (reg_idx == rsob_pkg::CfgIdxBlendMode) begin
      prdata = {{(rsob_pkg::CfgDataW-1){1'b0}}, blend_mode_r};
    end else begin
      prdata = '0;
    end
  end

  assign blend_mode = blend_mode_r;

endmodule

/* hw/rtl/rsob_front.sv */
module rsob_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsob_pkg::blend_mode_t  mode,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rsob_pkg::pix_t         src,
  input  rsob_pkg::pix_t         dst,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rsob_pkg::div_in_t      out_data
);

  localparam int unsigned NStg = 4;
  localparam int unsigned NC   = rsob_pkg::NumChan;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  // Stage 0 combinational
  logic [7:0]            inv;
  logic [NC-1:0][7:0]    s_ch;
  logic [NC-1:0][7:0]    d_ch;
  logic [15:0]           pa_nxt;
  logic [NC-1:0][15:0]   sc_nxt;
  logic                  byp_nxt;
  rsob_pkg::pix_t        bpix_nxt;

  // Stage 1 registers
  logic [15:0]           pa1_r;
  logic [NC-1:0][15:0]   sc1_r;
  logic [NC-1:0][7:0]    d1_r;
  logic [7:0]            sa1_r;
  logic                  byp1_r;
  rsob_pkg::pix_t        bpix1_r;

  // Stage 2
  logic [15:0]           xa;
  logic [31:0]           ea;
  logic [NC-1:0][23:0]   dp_nxt;
  logic [8:0]            qae2_r;
  logic [15:0]           xa2_r;
  logic [NC-1:0][23:0]   dp2_r;
  logic [NC-1:0][15:0]   sc2_r;
  logic [7:0]            sa2_r;
  logic                  byp2_r;
  rsob_pkg::pix_t        bpix2_r;

  // Stage 3
  logic [15:0]           qa;
  logic [8:0]            oa_full;
  logic [7:0]            oa_nxt;
  logic [NC-1:0][23:0]   x_nxt;
  logic [NC-1:0][39:0]   e_prod;
  logic [NC-1:0][15:0]   qe_nxt;
  logic [7:0]            oa3_r;
  logic [NC-1:0][15:0]   qe3_r;
  logic [NC-1:0][23:0]   x3_r;
  logic [NC-1:0][15:0]   sc3_r;
  logic                  byp3_r;
  rsob_pkg::pix_t        bpix3_r;

  // Stage 4
  logic [NC-1:0][15:0]              dpart;
  logic [NC-1:0][rsob_pkg::NumW-1:0] num_nxt;
  rsob_pkg::div_in_t                out_r;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NStg-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Products on the raw pixel; decide the pass-through cases
  always_comb begin
    s_ch[0] = src.red;
    s_ch[1] = src.green;
    s_ch[2] = src.blue;
    d_ch[0] = dst.red;
    d_ch[1] = dst.green;
    d_ch[2] = dst.blue;
    inv     = rsob_pkg::ChanMax - src.alpha;
    pa_nxt  = {8'd0, dst.alpha} * {8'd0, inv};
    for (int i = 0; i < NC; i++) begin
      sc_nxt[i] = {8'd0, s_ch[i]} * {8'd0, src.alpha};
    end
    byp_nxt  = (mode == rsob_pkg::MODE_REPLACE) || (src.alpha == 8'd0);
    bpix_nxt = (mode == rsob_pkg::MODE_REPLACE) ? src : dst;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa1_r   <= pa_nxt;
      sc1_r   <= sc_nxt;
      d1_r    <= d_ch;
      sa1_r   <= src.alpha;
      byp1_r  <= byp_nxt;
      bpix1_r <= bpix_nxt;
    end
  end

  // Alpha reciprocal product and d*dA*(255-sA)
  always_comb begin
    xa = pa1_r + {8'd0, rsob_pkg::RoundHalf};
    ea = {16'd0, xa} * {16'd0, rsob_pkg::Recip255};
    for (int i = 0; i < NC; i++) begin
      dp_nxt[i] = {16'd0, d1_r[i]} * {8'd0, pa1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qae2_r  <= ea[rsob_pkg::RecipShift +: 9];
      xa2_r   <= xa;
      dp2_r   <= dp_nxt;
      sc2_r   <= sc1_r;
      sa2_r   <= sa1_r;
      byp2_r  <= byp1_r;
      bpix2_r <= bpix1_r;
    end
  end

  // Finish output alpha; reciprocal product per color channel
  always_comb begin
    qa      = rsob_pkg::fix_div255({7'd0, qae2_r}, {8'd0, xa2_r});
    oa_full = {1'b0, sa2_r} + qa[8:0];
    oa_nxt  = oa_full[8] ? rsob_pkg::ChanMax : oa_full[7:0];
    for (int i = 0; i < NC; i++) begin
      x_nxt[i]  = dp2_r[i] + {16'd0, rsob_pkg::RoundHalf};
      e_prod[i] = {16'd0, x_nxt[i]} * {24'd0, rsob_pkg::Recip255};
      qe_nxt[i] = e_prod[i][rsob_pkg::RecipShift +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      oa3_r   <= oa_nxt;
      qe3_r   <= qe_nxt;
      x3_r    <= x_nxt;
      sc3_r   <= sc2_r;
      byp3_r  <= byp2_r;
      bpix3_r <= bpix2_r;
    end
  end

  // Form the rounded dividend per channel
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      dpart[i]   = rsob_pkg::fix_div255(qe3_r[i], x3_r[i]);
      num_nxt[i] = {1'b0, sc3_r[i]} + {1'b0, dpart[i]} + {10'd0, oa3_r[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      out_r.num  <= num_nxt;
      out_r.oa   <= oa3_r;
      out_r.byp  <= byp3_r;
      out_r.bpix <= bpix3_r;
    end
  end

endmodule

/* hw/rtl/rsob_div.sv */
module rsob_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rsob_pkg::div_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsob_pkg::pix_t     out_pix
);

  localparam int unsigned NStg = rsob_pkg::QuotW;
  localparam int unsigned NC   = rsob_pkg::NumChan;
  localparam int unsigned NW   = rsob_pkg::NumW;

  logic [NStg-1:0] v_r;
  logic [NStg-1:0] en;

  // Stage registers
  logic [NC-1:0][NW-1:0]   rem_r  [NStg];
  logic [NC-1:0][NStg-1:0] q_r    [NStg];
  logic [7:0]              oa_r   [NStg];
  logic                    byp_r  [NStg];
  rsob_pkg::pix_t          bpix_r [NStg];

  // Stage inputs and next values
  logic [NC-1:0][NW-1:0]   rem_in  [NStg];
  logic [NC-1:0][NStg-1:0] q_in    [NStg];
  logic [7:0]              oa_in   [NStg];
  logic [NC-1:0][NW-1:0]   rem_nxt [NStg];
  logic [NC-1:0][NStg-1:0] q_nxt   [NStg];
  logic [NW-1:0]           dsh     [NStg];

  logic [NC-1:0][7:0]      chan_res;
  logic                    oa_zero;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NStg-1] = !v_r[NStg-1] || out_ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NStg-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < NStg; k++) begin
      if (k == 0) begin
        rem_in[k] = in_data.num;
        q_in[k]   = '0;
        oa_in[k]  = in_data.oa;
      end else begin
        rem_in[k] = rem_r[k-1];
        q_in[k]   = q_r[k-1];
        oa_in[k]  = oa_r[k-1];
      end
      dsh[k] = {{(NW-8){1'b0}}, oa_in[k]} << (NStg - 1 - k);
      for (int i = 0; i < NC; i++) begin
        q_nxt[k][i] = q_in[k][i];
        if (rem_in[k][i] >= dsh[k]) begin
          rem_nxt[k][i]             = rem_in[k][i] - dsh[k];
          q_nxt[k][i][NStg - 1 - k] = 1'b1;
        end else begin
          rem_nxt[k][i]             = rem_in[k][i];
          q_nxt[k][i][NStg - 1 - k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NStg; k++) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        oa_r[k]  <= oa_in[k];
        if (k == 0) begin
          byp_r[k]  <= in_data.byp;
          bpix_r[k] <= in_data.bpix;
        end else begin
          byp_r[k]  <= byp_r[k-1];
          bpix_r[k] <= bpix_r[k-1];
        end
      end
    end
  end

  // Saturate, guard zero alpha, select the pass-through pixel
  always_comb begin
    oa_zero = (oa_r[NStg-1] == 8'd0);
    for (int i = 0; i < NC; i++) begin
      if (oa_zero) begin
        chan_res[i] = 8'd0;
      end else if (q_r[NStg-1][i][NStg-1]) begin
        chan_res[i] = rsob_pkg::ChanMax;
      end else begin
        chan_res[i] = q_r[NStg-1][i][7:0];
      end
    end
    if (byp_r[NStg-1]) begin
      out_pix = bpix_r[NStg-1];
    end else begin
      out_pix.red   = chan_res[0];
      out_pix.green = chan_res[1];
      out_pix.blue  = chan_res[2];
      out_pix.alpha = oa_r[NStg-1];
    end
  end

endmodule

/* hw/rtl/rgba8_source_over_blend_unit.sv */
// Source-over blend of straight-alpha RGBA8 pixels.
// in_px carries one source and one destination pixel per request; out_px
// returns the new destination pixel, one result per request, in order.
// Both channels use valid/ready; a request moves on a clock edge where both
// are high. The cfg_ port is APB-style: register 0 (byte address 0) holds
// blend_mode, 0 = source-over, 1 = replace with the source pixel. Change it
// only while no request is in flight.
// Throughput: one pixel per clock while out_px is not stalled. A request
// passes through four arithmetic stages (alpha products, reciprocal divide
// by 255, rounding sum) followed by a nine-stage restoring divider that
// yields one quotient bit per stage for each color channel.
// When out_px is stalled, the pipeline keeps filling its empty stages and
// in_px.ready drops only once every stage holds a pixel; nothing is lost or
// repeated. Reset (rst_n low, synchronous) empties the pipeline and sets
// blend_mode to source-over.
module rgba8_source_over_blend_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  rsob_in_if.sink                       in_px,
  rsob_out_if.source                    out_px,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rsob_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [rsob_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [rsob_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  rsob_pkg::blend_mode_t blend_mode;
  rsob_pkg::pix_t        src_pix;
  rsob_pkg::pix_t        dst_pix;
  rsob_pkg::pix_t        res_pix;
  rsob_pkg::div_in_t     div_data;
  logic                  div_valid;
  logic                  div_ready;

  // Pack the request fields
  assign src_pix = '{red: in_px.src_red, green: in_px.src_green,
                     blue: in_px.src_blue, alpha: in_px.src_alpha};
  assign dst_pix = '{red: in_px.dst_red, green: in_px.dst_green,
                     blue: in_px.dst_blue, alpha: in_px.dst_alpha};

  rsob_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .blend_mode (blend_mode)
  );

  rsob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (blend_mode),
    .in_valid  (in_px.valid),
    .in_ready  (in_px.ready),
    .src       (src_pix),
    .dst       (dst_pix),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  rsob_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (out_px.valid),
    .out_ready (out_px.ready),
    .out_pix   (res_pix)
  );

  // Unpack the result
  assign out_px.out_red   = res_pix.red;
  assign out_px.out_green = res_pix.green;
  assign out_px.out_blue  = res_pix.blue;
  assign out_px.out_alpha = res_pix.alpha;

endmodule

/* test/rgba8_source_over_blend_unit_tb.sv */
module rgba8_source_over_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef rsob_pkg::pix_t        pix_t;
  typedef rsob_pkg::blend_mode_t blend_mode_t;

  localparam int unsigned PipeDepth  = 13;
  localparam int unsigned QuietLimit = 2000;
  localparam logic [rsob_pkg::CfgAddrW-1:0] ModeAddr =
    rsob_pkg::CfgAddrW'(4 * rsob_pkg::CfgIdxBlendMode);
  // index 1 has no register behind it
  localparam logic [rsob_pkg::CfgAddrW-1:0] SpareRegAddr = 3'd4;

  logic clk;
  logic rst_n;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [rsob_pkg::CfgAddrW-1:0] cfg_paddr;
  logic [rsob_pkg::CfgDataW-1:0] cfg_pwdata;
  logic [rsob_pkg::CfgDataW-1:0] cfg_prdata;
  logic                          cfg_pready;

  rsob_in_if  in_if ();
  rsob_out_if out_if ();

  blend_mode_t active_mode = rsob_pkg::MODE_OVER;
  pix_t        pending_pixels[$];
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_request  = 0;
  bit          src_gaps      = 1'b1;
  bit          sink_gaps     = 1'b1;

  rgba8_source_over_blend_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_if),
    .out_px     (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Blend one color channel of the source over the destination
  function automatic logic [7:0] mix_channel(int unsigned sc, int unsigned dc,
                                             int unsigned sa, int unsigned da,
                                             int unsigned oa);
    int unsigned dst_term;
    int unsigned q;
    if (oa == 0) return 8'd0;
    dst_term = (dc * da * (rsob_pkg::ChanMax - sa) + rsob_pkg::RoundHalf)
               / rsob_pkg::ChanMax;
    q = (sc * sa + dst_term + oa / 2) / oa;
    return (q > rsob_pkg::ChanMax) ? rsob_pkg::ChanMax : q[7:0];
  endfunction

  // Expected new destination pixel for one request
  function automatic pix_t blend_pixel(pix_t src, pix_t dst, blend_mode_t mode);
    int unsigned sa;
    int unsigned da;
    int unsigned oa;
    pix_t r;
    sa = src.alpha;
    da = dst.alpha;
    if (mode == rsob_pkg::MODE_REPLACE) return src;
    // transparent source keeps the destination
    if (sa == 0) return dst;
    oa = sa + (da * (rsob_pkg::ChanMax - sa) + rsob_pkg::RoundHalf) / rsob_pkg::ChanMax;
    if (oa > rsob_pkg::ChanMax) oa = rsob_pkg::ChanMax;
    r.red   = mix_channel(src.red,   dst.red,   sa, da, oa);
    r.green = mix_channel(src.green, dst.green, sa, da, oa);
    r.blue  = mix_channel(src.blue,  dst.blue,  sa, da, oa);
    r.alpha = oa[7:0];
    return r;
  endfunction

  // Favor the ends of the range now and then
  function automatic logic [7:0] rand_level(int unsigned odds);
    case ($urandom_range(0, odds))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      3:       return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p.red   = rand_level(15);
    p.green = rand_level(15);
    p.blue  = rand_level(15);
    p.alpha = rand_level(7);
    return p;
  endfunction

  task automatic report_error(string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Offer one request and hold it until taken
  task automatic send_pixel(pix_t src, pix_t dst);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.src_red   <= src.red;
    in_if.src_green <= src.green;
    in_if.src_blue  <= src.blue;
    in_if.src_alpha <= src.alpha;
    in_if.dst_red   <= dst.red;
    in_if.dst_green <= dst.green;
    in_if.dst_blue  <= dst.blue;
    in_if.dst_alpha <= dst.alpha;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop offering, wait for every result, then let the pipeline settle
  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PipeDepth + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic [rsob_pkg::CfgAddrW-1:0] addr,
                           logic [rsob_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ModeAddr) active_mode = blend_mode_t'(data[0]);
  endtask

  task automatic read_reg(logic [rsob_pkg::CfgAddrW-1:0] addr,
                          output logic [rsob_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write the mode with random junk in the upper bits
  task automatic write_mode(blend_mode_t mode);
    logic [rsob_pkg::CfgDataW-1:0] v;
    v = $urandom();
    v[0] = mode;
    write_reg(ModeAddr, v);
  endtask

  task automatic check_mode_readback();
    logic [rsob_pkg::CfgDataW-1:0] got;
    read_reg(ModeAddr, got);
    if (got !== {{(rsob_pkg::CfgDataW-1){1'b0}}, active_mode})
      report_error($sformatf("blend_mode read 0x%0h want %0d", got, active_mode));
  endtask

  task automatic test_register_access();
    check_mode_readback();
    write_reg(SpareRegAddr, 32'hFFFF_FFFF);
    check_mode_readback();
    write_mode(rsob_pkg::MODE_REPLACE);
    check_mode_readback();
    write_reg(ModeAddr, 32'hFFFF_FFFE);
    check_mode_readback();
  endtask

  task automatic test_directed_over();
    write_mode(rsob_pkg::MODE_OVER);
    // transparent source leaves the destination alone
    send_pixel(pix_t'{8'd200, 8'd100, 8'd50, 8'd0}, pix_t'{8'd1, 8'd2, 8'd3, 8'd4});
    send_pixel(pix_t'{8'd255, 8'd255, 8'd255, 8'd0}, pix_t'{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_t'{8'd0, 8'd0, 8'd0, 8'd0}, pix_t'{8'd0, 8'd0, 8'd0, 8'd0});
    // opaque source
    send_pixel(pix_t'{8'd12, 8'd34, 8'd56, 8'd255}, pix_t'{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_t'{8'd255, 8'd255, 8'd255, 8'd255}, pix_t'{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_t'{8'd9, 8'd0, 8'd255, 8'd255}, pix_t'{8'd7, 8'd255, 8'd0, 8'd0});
    // faint source over empty and full destinations
    send_pixel(pix_t'{8'd255, 8'd0, 8'd128, 8'd1}, pix_t'{8'd255, 8'd255, 8'd255, 8'd0});
    send_pixel(pix_t'{8'd255, 8'd255, 8'd255, 8'd1}, pix_t'{8'd0, 8'd0, 8'd0, 8'd255});
    send_pixel(pix_t'{8'd255, 8'd255, 8'd255, 8'd1}, pix_t'{8'd255, 8'd255, 8'd255, 8'd1});
    send_pixel(pix_t'{8'd0, 8'd255, 8'd0, 8'd254}, pix_t'{8'd255, 8'd0, 8'd255, 8'd255});
    send_pixel(pix_t'{8'd255, 8'd0, 8'd127, 8'd128}, pix_t'{8'd0, 8'd255, 8'd128, 8'd128});
    // bright over bright probes the saturation clamp
    send_pixel(pix_t'{8'd255, 8'd255, 8'd254, 8'd2}, pix_t'{8'd255, 8'd254, 8'd255, 8'd254});
    send_pixel(pix_t'{8'hAA, 8'h55, 8'hAA, 8'h80}, pix_t'{8'h55, 8'hAA, 8'h55, 8'h7F});
    send_pixel(pix_t'{8'h55, 8'hAA, 8'h55, 8'h7F}, pix_t'{8'hAA, 8'h55, 8'hAA, 8'h80});
    drain_pipe();
  endtask

  task automatic test_replace_mode();
    write_mode(rsob_pkg::MODE_REPLACE);
    send_pixel(pix_t'{8'd200, 8'd100, 8'd50, 8'd0}, pix_t'{8'd1, 8'd2, 8'd3, 8'd4});
    send_pixel(pix_t'{8'd255, 8'd255, 8'd255, 8'd255}, pix_t'{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel(pix_t'{8'd0, 8'd0, 8'd0, 8'd0}, pix_t'{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_t'{8'hAA, 8'h55, 8'hAA, 8'h55}, pix_t'{8'h55, 8'hAA, 8'h55, 8'hAA});
    send_pixel(pix_t'{8'd3, 8'd250, 8'd77, 8'd1}, pix_t'{8'd9, 8'd8, 8'd7, 8'd6});
    drain_pipe();
  endtask

  task automatic test_random_pixels();
    for (int phase = 0; phase < 6; phase++) begin
      write_mode((phase % 3 == 1) ? rsob_pkg::MODE_REPLACE : rsob_pkg::MODE_OVER);
      src_gaps  = (phase != 2);
      sink_gaps = (phase != 4);
      repeat (130) send_pixel(rand_pixel(), rand_pixel());
      drain_pipe();
    end
  endtask

  // Hold off the result side so the pipeline fills and stalls its input
  task automatic test_output_backpressure();
    write_mode(rsob_pkg::MODE_OVER);
    src_gaps     = 1'b0;
    sink_gaps    = 1'b0;
    hold_request = 80;
    repeat (60) send_pixel(rand_pixel(), rand_pixel());
    drain_pipe();
  endtask

  task automatic test_full_rate_stream();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    repeat (100) send_pixel(rand_pixel(), rand_pixel());
    drain_pipe();
  endtask

  // Result side ready: long holds on request, random bursts otherwise
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        out_if.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Check results first, then record the request taken at the same edge
  always @(posedge clk) begin : scoreboard
    pix_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_pixels.size() == 0) begin
          report_error("result with no request pending");
        end else begin
          want = pending_pixels.pop_front();
          check_field("red",   out_if.out_red,   want.red);
          check_field("green", out_if.out_green, want.green);
          check_field("blue",  out_if.out_blue,  want.blue);
          check_field("alpha", out_if.out_alpha, want.alpha);
        end
      end
      if (in_if.valid && in_if.ready)
        pending_pixels.push_back(blend_pixel(
          pix_t'{in_if.src_red, in_if.src_green, in_if.src_blue, in_if.src_alpha},
          pix_t'{in_if.dst_red, in_if.dst_green, in_if.dst_blue, in_if.dst_alpha},
          active_mode));
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    in_if.valid     <= 1'b0;
    in_if.src_red   <= '0;
    in_if.src_green <= '0;
    in_if.src_blue  <= '0;
    in_if.src_alpha <= '0;
    in_if.dst_red   <= '0;
    in_if.dst_green <= '0;
    in_if.dst_blue  <= '0;
    in_if.dst_alpha <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_directed_over();
    test_replace_mode();
    test_random_pixels();
    test_output_backpressure();
    test_full_rate_stream();

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PipeDepth + 7) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
